/* rtl/core/sidht_pkg.sv */
// sidht_pkg: shared types, field widths, codes and bucket hash of the stream id hash table
`timescale 1ns / 1ps

package sidht_pkg;

  // item field widths
  localparam int KEY_W      = 31;
  localparam int SLOT_FLD_W = 8;
  localparam int TOTAL_W    = 8;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 24;

  // hash shift amounts
  localparam int HASH_SH_A = 20;
  localparam int HASH_SH_B = 12;
  localparam int HASH_SH_C = 7;
  localparam int HASH_SH_D = 4;

  // operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_FIND   = 1'b1;

  // result kinds
  typedef logic [1:0] res_t;
  localparam res_t RES_INS_OK  = 2'd0;
  localparam res_t RES_INS_REJ = 2'd1;
  localparam res_t RES_HIT     = 2'd2;
  localparam res_t RES_MISS    = 2'd3;

  // controller to datapath commands
  typedef struct packed {
    logic load;        // take the input item
    logic start_walk;  // begin a chain walk at the bucket head
    logic step;        // follow the next link
    logic commit;      // write an accepted insert
    logic emit;        // load the output register
    res_t res;         // kind of result to emit
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic op;          // operation of the current item
    logic insert_ok;   // slot in range and free
    logic bucket_hit;  // bucket chain is non-empty
    logic key_match;   // current slot holds the key
    logic have_next;   // current slot has a next link
    logic steps_last;  // walk limit reached at this link
  } stat_t;

  // shift-xor mix of a key, full 32-bit result
  function automatic logic [31:0] bucket_hash(input logic [KEY_W-1:0] key);
    logic [31:0] h;
    h = {1'b0, key};
    h = h ^ (h >> HASH_SH_A) ^ (h >> HASH_SH_B);
    h = h ^ (h >> HASH_SH_C) ^ (h >> HASH_SH_D);
    return h;
  endfunction

endpackage

/* rtl/core/sidht_dp.sv */
// sidht_dp: bucket and slot stores, chain walk registers and result register
`timescale 1ns / 1ps

module sidht_dp #(
  parameter int BUCKET_COUNT = 64,
  parameter int SLOT_COUNT   = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_op,
  input  logic [sidht_pkg::KEY_W-1:0]         in_key,
  input  logic [sidht_pkg::SLOT_FLD_W-1:0]    in_slot,
  input  sidht_pkg::cmd_t                     cmd,
  output sidht_pkg::stat_t                    stat,
  output logic                                res_found,
  output logic [sidht_pkg::SLOT_FLD_W-1:0]    res_slot,
  output logic                                res_status,
  output logic [sidht_pkg::TOTAL_W-1:0]       res_total
);

  localparam int SW    = $clog2(SLOT_COUNT);
  localparam int BW    = $clog2(BUCKET_COUNT);
  localparam int ENT_W = SW + sidht_pkg::KEY_W;

  // item registers
  logic                               op_r;
  logic [sidht_pkg::KEY_W-1:0]        key_r;
  logic [sidht_pkg::SLOT_FLD_W-1:0]   slot8_r;
  logic [SW-1:0]                      slot_r;
  logic                               slot_ok_r;
  logic [BW-1:0]                      bucket_r;

  // stores
  logic [SW-1:0]                      head_mem [BUCKET_COUNT];
  logic [SW-1:0]                      head_rd_r;
  logic                               root_head_r;
  logic [BUCKET_COUNT-1:0]            bucket_valid_r;
  logic [ENT_W-1:0]                   slot_mem [SLOT_COUNT];
  logic [ENT_W-1:0]                   slot_rd_r;
  logic [SLOT_COUNT-1:0]              next_valid_r;
  logic [SLOT_COUNT-1:0]              used_r;

  // walk and counter
  logic [SW-1:0]                      cur_r;
  logic [SW-1:0]                      steps_r;
  logic [sidht_pkg::TOTAL_W-1:0]      count_r;
  logic [sidht_pkg::TOTAL_W-1:0]      count_inc;

  logic [BW-1:0]                      in_bucket;
  logic [SW-1:0]                      in_slot_idx;
  logic                               in_slot_ok;
  logic [BW-1:0]                      head_addr;
  logic [SW-1:0]                      head_val;
  logic [SW-1:0]                      slot_addr;
  logic [SW-1:0]                      ent_next;
  logic [sidht_pkg::KEY_W-1:0]        cur_key;

  // input decode
  assign in_bucket   = BW'(sidht_pkg::bucket_hash(in_key));
  assign in_slot_idx = SW'(32'(in_slot));
  assign in_slot_ok  = 32'(in_slot) < 32'(SLOT_COUNT);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r      <= in_op;
      key_r     <= in_key;
      slot8_r   <= in_slot;
      slot_r    <= in_slot_idx;
      slot_ok_r <= in_slot_ok;
      bucket_r  <= in_bucket;
    end
  end

  // bucket head memory, root slot stands in for bucket 0 until first written
  assign head_addr = cmd.load ? in_bucket : bucket_r;
  assign head_val  = (bucket_r == '0 && root_head_r) ? '0 : head_rd_r;

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      head_mem[bucket_r] <= slot_r;
    end
    head_rd_r <= head_mem[head_addr];
  end

  // slot entry memory: next link above the key
  assign ent_next  = slot_rd_r[ENT_W-1:sidht_pkg::KEY_W];
  assign cur_key   = (cur_r == '0) ? '0 : slot_rd_r[sidht_pkg::KEY_W-1:0];
  assign slot_addr = cmd.start_walk ? head_val : (cmd.step ? ent_next : cur_r);

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      slot_mem[slot_r] <= {head_val, key_r};
    end
    slot_rd_r <= slot_mem[slot_addr];
  end

  // valid and used flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_head_r    <= 1'b1;
      bucket_valid_r <= BUCKET_COUNT'(1);
      next_valid_r   <= '0;
      used_r         <= SLOT_COUNT'(1);
      count_r        <= '0;
    end else if (cmd.commit) begin
      if (bucket_r == '0) begin
        root_head_r <= 1'b0;
      end
      bucket_valid_r[bucket_r] <= 1'b1;
      next_valid_r[slot_r]     <= bucket_valid_r[bucket_r];
      used_r[slot_r]           <= 1'b1;
      count_r                  <= count_inc;
    end
  end

  assign count_inc = (count_r == '1) ? count_r : count_r + 1'b1;

  // chain walk position
  always_ff @(posedge clk) begin
    if (cmd.start_walk) begin
      cur_r   <= head_val;
      steps_r <= '0;
    end else if (cmd.step) begin
      cur_r   <= ent_next;
      steps_r <= steps_r + 1'b1;
    end
  end

  // status to the controller
  always_comb begin
    stat.op         = op_r;
    stat.insert_ok  = slot_ok_r && !used_r[slot_r];
    stat.bucket_hit = bucket_valid_r[bucket_r];
    stat.key_match  = (cur_key == key_r);
    stat.have_next  = next_valid_r[cur_r];
    stat.steps_last = (steps_r == SW'(SLOT_COUNT - 1));
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      res_total <= cmd.commit ? count_inc : count_r;
      case (cmd.res)
        sidht_pkg::RES_INS_OK: begin
          res_found  <= 1'b1;
          res_slot   <= slot8_r;
          res_status <= 1'b0;
        end
        sidht_pkg::RES_INS_REJ: begin
          res_found  <= 1'b0;
          res_slot   <= slot8_r;
          res_status <= 1'b1;
        end
        sidht_pkg::RES_HIT: begin
          res_found  <= 1'b1;
          res_slot   <= sidht_pkg::SLOT_FLD_W'(cur_r);
          res_status <= 1'b0;
        end
        default: begin
          res_found  <= 1'b0;
          res_slot   <= '0;
          res_status <= 1'b0;
        end
      endcase
    end
  end

endmodule

/* rtl/core/sidht_ctrl.sv */
// sidht_ctrl: item sequencing state machine and output valid
`timescale 1ns / 1ps

module sidht_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  logic             out_tready,
  input  sidht_pkg::stat_t stat,
  output sidht_pkg::cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_HEAD = 2'd1;
  localparam logic [1:0] ST_LINK = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       emit_ok;

  // result register free or being drained this cycle
  assign emit_ok   = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE);

  // next state and commands
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_HEAD;
        end
      end
      ST_HEAD: begin
        if (stat.op == sidht_pkg::OP_INSERT) begin
          if (emit_ok) begin
            cmd.emit   = 1'b1;
            cmd.commit = stat.insert_ok;
            cmd.res    = stat.insert_ok ? sidht_pkg::RES_INS_OK : sidht_pkg::RES_INS_REJ;
            state_nxt  = ST_IDLE;
          end
        end else if (!stat.bucket_hit) begin
          if (emit_ok) begin
            cmd.emit  = 1'b1;
            cmd.res   = sidht_pkg::RES_MISS;
            state_nxt = ST_IDLE;
          end
        end else begin
          cmd.start_walk = 1'b1;
          state_nxt      = ST_LINK;
        end
      end
      ST_LINK: begin
        if (stat.key_match) begin
          if (emit_ok) begin
            cmd.emit  = 1'b1;
            cmd.res   = sidht_pkg::RES_HIT;
            state_nxt = ST_IDLE;
          end
        end else if (!stat.have_next || stat.steps_last) begin
          if (emit_ok) begin
            cmd.emit  = 1'b1;
            cmd.res   = sidht_pkg::RES_MISS;
            state_nxt = ST_IDLE;
          end
        end else begin
          cmd.step = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // output valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

/* rtl/core/stream_id_chained_hash_table_unit.sv */
// stream_id_chained_hash_table_unit: top level of the chained stream id hash table
//
//   channel  direction  group                      item
//   in_      slave      tvalid tready tdata tuser  insert or find request
//   out_     master     tvalid tready tdata        one result per request
//
// An insert is settled in the head state; a find is settled there on an empty
// bucket and otherwise walks the chain in the link state, one link per cycle
// from the slot entry memory. The next item is taken only back in idle.
// Reset is synchronous and needs no clearing pass: flags live in flip-flops.
// A result waits in the output register while the next item is taken; only a
// second result stalls behind an unread one.
`timescale 1ns / 1ps

module stream_id_chained_hash_table_unit #(
  parameter int BUCKET_COUNT = 64,
  parameter int SLOT_COUNT   = 256
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // stream_key [30:0], entry_slot [38:31], zero [39]
  input  logic [sidht_pkg::IN_DATA_W-1:0]      in_tdata,
  // operation [0]
  input  logic                                 in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // found [0], result_slot [8:1], status [9], entry_total [17:10], zero [23:18]
  output logic [sidht_pkg::OUT_DATA_W-1:0]     out_tdata
);

  sidht_pkg::cmd_t                  cmd;
  sidht_pkg::stat_t                 stat;
  logic                             res_found;
  logic [sidht_pkg::SLOT_FLD_W-1:0] res_slot;
  logic                             res_status;
  logic [sidht_pkg::TOTAL_W-1:0]    res_total;

  // sequencing
  sidht_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // stores and walk
  sidht_dp #(
    .BUCKET_COUNT (BUCKET_COUNT),
    .SLOT_COUNT   (SLOT_COUNT)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_op      (in_tuser),
    .in_key     (in_tdata[sidht_pkg::KEY_W-1:0]),
    .in_slot    (in_tdata[sidht_pkg::KEY_W +: sidht_pkg::SLOT_FLD_W]),
    .cmd        (cmd),
    .stat       (stat),
    .res_found  (res_found),
    .res_slot   (res_slot),
    .res_status (res_status),
    .res_total  (res_total)
  );

  // result packing
  assign out_tdata = {6'b0, res_total, res_status, res_slot, res_found};

endmodule

/* rtl/core/sidht_checker.sv */
// sidht_checker: port-level assertions for the hash table unit and its bind
`timescale 1ns / 1ps

module sidht_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [sidht_pkg::OUT_DATA_W-1:0] out_tdata
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // one item at a time: no accept in the cycle after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("item accepted while previous one in work");

  // a rejected insert never reports success
  a_rej_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[9] && out_tdata[0]))
    else $error("result both found and rejected");

  // a find miss reports slot zero
  a_miss_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] && !out_tdata[9] |-> out_tdata[8:1] == 8'd0)
    else $error("miss with non-zero slot");

endmodule

bind stream_id_chained_hash_table_unit sidht_checker u_sidht_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

/* test/tb_top.sv */
// tb_top: self-checking stream testbench for the chained stream id hash table unit
`timescale 1ns / 1ps

module tb_top;

  localparam int NUM_BUCKETS  = 64;
  localparam int NUM_SLOTS    = 256;
  localparam int RANDOM_ITEMS = 1500;
  localparam int CYCLE_LIMIT  = 3000000;
  localparam int DRAIN_CYCLES = 32;
  localparam int PRESSURE_AT  = 1200;
  localparam int PRESSURE_LEN = 400;
  localparam int COUNT_MAX    = 255;

  // status codes of a result item
  localparam logic ST_OK       = 1'b0;
  localparam logic ST_REJECTED = 1'b1;

  typedef struct packed {
    logic                             op;
    logic [sidht_pkg::KEY_W-1:0]      key;
    logic [sidht_pkg::SLOT_FLD_W-1:0] slot;
  } request_t;

  typedef struct packed {
    logic                             found;
    logic [sidht_pkg::SLOT_FLD_W-1:0] rslot;
    logic                             status;
    logic [sidht_pkg::TOTAL_W-1:0]    total;
  } result_t;

  typedef struct packed {
    request_t req;
    logic     typed;
    result_t  res;
  } dir_row_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic [sidht_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic                             in_tuser = 1'b0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [sidht_pkg::OUT_DATA_W-1:0] out_tdata;

  // shadow of the table contents
  logic [sidht_pkg::SLOT_FLD_W-1:0] chain_head [NUM_BUCKETS];
  logic                             chain_live [NUM_BUCKETS];
  logic [sidht_pkg::SLOT_FLD_W-1:0] link_next  [NUM_SLOTS];
  logic                             link_live  [NUM_SLOTS];
  logic [sidht_pkg::KEY_W-1:0]      slot_key   [NUM_SLOTS];
  logic                             slot_taken [NUM_SLOTS];
  logic [sidht_pkg::TOTAL_W-1:0]    insert_total;

  result_t  pending_results [$];
  dir_row_t dir_rows [$];

  int errors = 0;
  int results_checked = 0;
  int cycle_count = 0;
  int tx_burst = 0;
  int n_ins_ok = 0;
  int n_ins_rej = 0;
  int n_finds = 0;
  int n_hits = 0;

  stream_id_chained_hash_table_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #4 clk = ~clk;

  // shift-xor mix of a key down to a bucket index
  function automatic int key_bucket(input logic [sidht_pkg::KEY_W-1:0] key);
    logic [31:0] m;
    m = {1'b0, key};
    m = m ^ (m >> sidht_pkg::HASH_SH_A) ^ (m >> sidht_pkg::HASH_SH_B);
    m = m ^ (m >> sidht_pkg::HASH_SH_C) ^ (m >> sidht_pkg::HASH_SH_D);
    return int'(m & (NUM_BUCKETS - 1));
  endfunction

  // apply one request to the shadow table and return its result item
  function automatic result_t hash_table_predict(input request_t rq);
    result_t r;
    int b;
    int steps;
    logic have;
    logic [sidht_pkg::SLOT_FLD_W-1:0] cur;
    r = '0;
    b = key_bucket(rq.key);
    if (rq.op == sidht_pkg::OP_INSERT) begin
      r.rslot = rq.slot;
      if (int'(rq.slot) >= NUM_SLOTS || slot_taken[rq.slot]) begin
        r.status = ST_REJECTED;
        n_ins_rej++;
      end else begin
        link_next[rq.slot]  = chain_head[b];
        link_live[rq.slot]  = chain_live[b];
        chain_head[b]       = rq.slot;
        chain_live[b]       = 1'b1;
        slot_key[rq.slot]   = rq.key;
        slot_taken[rq.slot] = 1'b1;
        if (insert_total < COUNT_MAX) insert_total++;
        r.found  = 1'b1;
        r.status = ST_OK;
        n_ins_ok++;
      end
    end else begin
      n_finds++;
      have  = chain_live[b];
      cur   = chain_head[b];
      steps = 0;
      // walk the chain from its head, first match wins
      while (have && steps < NUM_SLOTS) begin
        if (slot_key[cur] == rq.key) begin
          r.found = 1'b1;
          r.rslot = cur;
          n_hits++;
          break;
        end
        have = link_live[cur];
        cur  = link_next[cur];
        steps++;
      end
    end
    r.total = insert_total;
    return r;
  endfunction

  function automatic dir_row_t dir_row(input logic op,
                                       input logic [sidht_pkg::KEY_W-1:0] key,
                                       input logic [sidht_pkg::SLOT_FLD_W-1:0] slot,
                                       input logic typed,
                                       input logic found,
                                       input logic [sidht_pkg::SLOT_FLD_W-1:0] rslot,
                                       input logic status,
                                       input logic [sidht_pkg::TOTAL_W-1:0] total);
    dir_row_t d;
    d.req   = '{op: op, key: key, slot: slot};
    d.typed = typed;
    d.res   = '{found: found, rslot: rslot, status: status, total: total};
    return d;
  endfunction

  // key already held by some slot, the root key if none is hit quickly
  function automatic logic [sidht_pkg::KEY_W-1:0] stored_key();
    int s;
    int tries;
    for (tries = 0; tries < 32; tries++) begin
      s = $urandom_range(0, NUM_SLOTS - 1);
      if (slot_taken[s]) return slot_key[s];
    end
    return slot_key[0];
  endfunction

  // mostly well-formed traffic: inserts into free slots, finds of stored keys
  function automatic request_t random_request();
    request_t rq;
    int pick;
    int s;
    int n;
    rq.op   = ($urandom_range(0, 99) < 40) ? sidht_pkg::OP_INSERT : sidht_pkg::OP_FIND;
    rq.slot = sidht_pkg::SLOT_FLD_W'($urandom_range(0, NUM_SLOTS - 1));
    pick    = $urandom_range(0, 99);
    if (rq.op == sidht_pkg::OP_INSERT) begin
      if (n_ins_ok < NUM_SLOTS - 1 && $urandom_range(0, 99) < 80) begin
        s = $urandom_range(1, NUM_SLOTS - 1);
        for (n = 0; n < NUM_SLOTS && slot_taken[s]; n++) s = (s % (NUM_SLOTS - 1)) + 1;
        rq.slot = sidht_pkg::SLOT_FLD_W'(s);
      end
      if (pick < 50)      rq.key = sidht_pkg::KEY_W'($urandom);
      else if (pick < 75) rq.key = sidht_pkg::KEY_W'($urandom_range(0, 511));
      else                rq.key = stored_key();
    end else begin
      if (pick < 60)      rq.key = stored_key();
      else if (pick < 80) rq.key = sidht_pkg::KEY_W'($urandom_range(0, 511));
      else                rq.key = sidht_pkg::KEY_W'($urandom);
    end
    return rq;
  endfunction

  // sender gap: mostly none or short, a few long, with bursts of no idling
  function automatic int tx_gap();
    int r;
    if (tx_burst > 0) begin
      tx_burst--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) tx_burst = $urandom_range(30, 100);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  // receiver ready: random stalls, free-running stretches, one long hold-off
  always @(posedge clk) begin : rx_ready_gen
    static int hold = 0;
    static int free_run = 0;
    static int rx_cycles = 0;
    int r;
    rx_cycles++;
    if (rx_cycles == PRESSURE_AT) begin
      hold = PRESSURE_LEN;
      free_run = 0;
    end
    if (hold > 0) begin
      hold--;
      out_tready <= 1'b0;
    end else if (free_run > 0) begin
      free_run--;
      out_tready <= 1'b1;
    end else begin
      r = $urandom_range(0, 999);
      if (r < 10) begin
        free_run = $urandom_range(50, 300);
        out_tready <= 1'b1;
      end else if (r < 700) begin
        out_tready <= 1'b1;
      end else if (r < 950) begin
        hold = $urandom_range(0, 2);
        out_tready <= 1'b0;
      end else if (r < 990) begin
        hold = $urandom_range(3, 20);
        out_tready <= 1'b0;
      end else begin
        hold = $urandom_range(30, 80);
        out_tready <= 1'b0;
      end
    end
  end

  // compare each result item with the oldest pending expectation
  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.found  = out_tdata[0];
      got.rslot  = out_tdata[8:1];
      got.status = out_tdata[9];
      got.total  = out_tdata[17:10];
      if (pending_results.size() == 0) begin
        $error("result item with nothing pending: tdata %h", out_tdata);
        errors++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (got.found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, got.found);
          errors++;
        end
        if (got.rslot !== want.rslot) begin
          $error("result_slot: expected %0d, got %0d", want.rslot, got.rslot);
          errors++;
        end
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          errors++;
        end
        if (got.total !== want.total) begin
          $error("entry_total: expected %0d, got %0d", want.total, got.total);
          errors++;
        end
      end
    end
  end

  // run-time limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // reset, directed rows, random traffic, drain and verdict
  initial begin : stimulus
    request_t rq;
    result_t  model_res;
    dir_row_t d;
    int idx;
    int gap;
    int n_items;

    for (idx = 0; idx < NUM_BUCKETS; idx++) begin
      chain_head[idx] = '0;
      chain_live[idx] = 1'b0;
    end
    for (idx = 0; idx < NUM_SLOTS; idx++) begin
      link_next[idx]  = '0;
      link_live[idx]  = 1'b0;
      slot_key[idx]   = '0;
      slot_taken[idx] = 1'b0;
    end
    // root entry: slot 0 holds key 0 at the head of its bucket
    chain_head[key_bucket('0)] = '0;
    chain_live[key_bucket('0)] = 1'b1;
    slot_taken[0] = 1'b1;
    insert_total  = '0;

    // root hit, root slot reject, miss, top key into top slot
    dir_rows.push_back(dir_row(sidht_pkg::OP_FIND,   31'h0,        8'd0,
                               1, 1, 8'd0,   ST_OK, 8'd0));
    dir_rows.push_back(dir_row(sidht_pkg::OP_INSERT, 31'h0,        8'd0,
                               1, 0, 8'd0,   ST_REJECTED, 8'd0));
    dir_rows.push_back(dir_row(sidht_pkg::OP_FIND,   31'h7FFFFFFF, 8'd255,
                               1, 0, 8'd0,   ST_OK, 8'd0));
    dir_rows.push_back(dir_row(sidht_pkg::OP_INSERT, 31'h7FFFFFFF, 8'd255,
                               1, 1, 8'd255, ST_OK, 8'd1));
    dir_rows.push_back(dir_row(sidht_pkg::OP_FIND,   31'h7FFFFFFF, 8'd0,
                               1, 1, 8'd255, ST_OK, 8'd1));
    dir_rows.push_back(dir_row(sidht_pkg::OP_INSERT, 31'h1234,     8'd255,
                               1, 0, 8'd255, ST_REJECTED, 8'd1));
    // duplicate of the root key lands at the chain head
    dir_rows.push_back(dir_row(sidht_pkg::OP_INSERT, 31'h0,        8'd1,
                               1, 1, 8'd1,   ST_OK, 8'd2));
    dir_rows.push_back(dir_row(sidht_pkg::OP_FIND,   31'h0,        8'd77,
                               1, 1, 8'd1,   ST_OK, 8'd2));
    // alternating bit patterns in key and slot
    dir_rows.push_back(dir_row(sidht_pkg::OP_INSERT, 31'h55555555, 8'hAA,
                               0, 0, 8'd0, ST_OK, 8'd0));
    dir_rows.push_back(dir_row(sidht_pkg::OP_INSERT, 31'h2AAAAAAA, 8'h55,
                               0, 0, 8'd0, ST_OK, 8'd0));
    dir_rows.push_back(dir_row(sidht_pkg::OP_FIND,   31'h55555555, 8'h55,
                               0, 0, 8'd0, ST_OK, 8'd0));
    dir_rows.push_back(dir_row(sidht_pkg::OP_FIND,   31'h2AAAAAAA, 8'hAA,
                               0, 0, 8'd0, ST_OK, 8'd0));
    // duplicate key in two fresh slots, newest wins
    dir_rows.push_back(dir_row(sidht_pkg::OP_INSERT, 31'h12345,    8'd128,
                               0, 0, 8'd0, ST_OK, 8'd0));
    dir_rows.push_back(dir_row(sidht_pkg::OP_INSERT, 31'h12345,    8'd127,
                               0, 0, 8'd0, ST_OK, 8'd0));
    dir_rows.push_back(dir_row(sidht_pkg::OP_FIND,   31'h12345,    8'd0,
                               0, 0, 8'd0, ST_OK, 8'd0));
    dir_rows.push_back(dir_row(sidht_pkg::OP_FIND,   31'h1,        8'd3,
                               0, 0, 8'd0, ST_OK, 8'd0));
    dir_rows.push_back(dir_row(sidht_pkg::OP_INSERT, 31'h1,        8'd1,
                               1, 0, 8'd1, ST_REJECTED, 8'd6));
    dir_rows.push_back(dir_row(sidht_pkg::OP_FIND,   31'h40000000, 8'd0,
                               0, 0, 8'd0, ST_OK, 8'd0));
    dir_rows.push_back(dir_row(sidht_pkg::OP_INSERT, 31'h40000000, 8'd2,
                               0, 0, 8'd0, ST_OK, 8'd0));
    dir_rows.push_back(dir_row(sidht_pkg::OP_FIND,   31'h40000000, 8'd255,
                               0, 0, 8'd0, ST_OK, 8'd0));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    n_items = dir_rows.size() + RANDOM_ITEMS;
    for (idx = 0; idx < n_items; idx++) begin
      if (idx < dir_rows.size()) begin
        d  = dir_rows[idx];
        rq = d.req;
      end else begin
        d  = '0;
        rq = random_request();
      end
      gap = tx_gap();
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata  <= {1'b0, rq.slot, rq.key};
      in_tuser  <= rq.op;
      do @(posedge clk); while (!in_tready);
      // item accepted at this edge
      model_res = hash_table_predict(rq);
      if (d.typed) pending_results.push_back(d.res);
      else         pending_results.push_back(model_res);
    end
    in_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("summary: %0d items, %0d inserts taken, %0d rejected, %0d finds (%0d hits)",
             n_items, n_ins_ok, n_ins_rej, n_finds, n_hits);
    $display("summary: %0d result items checked, final entry count %0d, %0d cycles",
             results_checked, insert_total, cycle_count);
    if (errors == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

endmodule

/* files.f */
rtl/core/sidht_pkg.sv
rtl/core/sidht_dp.sv
rtl/core/sidht_ctrl.sv
rtl/core/stream_id_chained_hash_table_unit.sv
rtl/core/sidht_checker.sv
test/tb_top.sv
